// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check in the same cycle
`define PLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check in the next cycle
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pli_pkg.sv =====
package pli_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int DATA_W          = 32;
  localparam int IDX_W           = 5;
  localparam int CFG_W           = 6;

  localparam logic [DATA_W-1:0] FALLBACK_Y = DATA_W'(-(99 << FRAC_BITS));

  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_Q_W    = 34;
  localparam int DIV_STEPS  = DIV_Q_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } pli_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_SUM,
    ST_DIV
  } pli_state_t;

  typedef struct packed {
    pli_cmd_t                  command;
    logic [IDX_W-1:0]          entry_index;
    logic signed [DATA_W-1:0]  point_x;
    logic signed [DATA_W-1:0]  point_y;
    logic signed [DATA_W-1:0]  query_x;
  } pli_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_y;
    logic                      found;
  } pli_out_t;

endpackage

// ===== rtl/pli_ram.sv =====
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pli_div.sv =====
module pli_div import pli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_Q_W-1:0]   quot
);

  localparam int STEP_W = DIV_DEN_W + DIV_Q_W;

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;
  logic [STEP_W-1:0]    s1;
  logic [STEP_W-1:0]    s2;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [STEP_W-1:0] div_step(input logic [DIV_DEN_W-1:0] r,
                                                 input logic [DIV_Q_W-1:0] qs,
                                                 input logic [DIV_DEN_W-1:0] dv);
    logic [DIV_DEN_W:0] r_ext;
    logic               q_bit;
    r_ext = {r, qs[DIV_Q_W-1]};
    q_bit = (r_ext >= {1'b0, dv});
    if (q_bit) begin
      r_ext = r_ext - {1'b0, dv};
    end
    return {r_ext[DIV_DEN_W-1:0], qs[DIV_Q_W-2:0], q_bit};
  endfunction

  always_comb begin
    s1 = div_step(rem, quot, den);
    s2 = div_step(s1[STEP_W-1:DIV_Q_W], s1[DIV_Q_W-1:0], den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (run) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      quot <= num[DIV_Q_W-1:0];
    end else if (run) begin
      rem  <= s2[STEP_W-1:DIV_Q_W];
      quot <= s2[DIV_Q_W-1:0];
    end
  end

endmodule

// ===== rtl/piecewise_linear_interpolator.sv =====
// Piecewise-linear table interpolator, breakpoints and results in signed Q16.16.
// Input beats arrive on item and are taken at an edge with start high and busy low.
// A write beat (command write) stores one breakpoint in the same cycle and never
// raises busy; writes to an index at or above TABLE_DEPTH are dropped.
// A query beat over two or more points raises busy and scans the table one entry
// per cycle out of the breakpoint RAM, then runs a two-step multiply and a divider
// that retires two quotient bits per cycle.
// A hit on the segment ending at entry i strobes result_valid once the scan, the
// multiply and the divider are done (the divider is skipped when the segment has
// zero width); a miss strobes it after the last segment is scanned, and a query
// with fewer than two points answers in the next cycle.
// Each result is shown for one cycle only; the receiver cannot stall it.
// busy falls in the cycle the result is shown, so the next beat may follow at once.
// points_in_use is written on the cfg channel, which is always ready; write it
// only while the block is idle.
// Reset clears the control state and points_in_use; table contents stay
// undefined until written.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pli_in_t          item,
  output logic             result_valid,
  output pli_out_t         result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MEM_W  = 2 * DATA_W;

  pli_state_t state;
  pli_state_t state_next;

  logic [CFG_W-1:0]         points_in_use;
  logic [CNT_W-1:0]         n_cfg;
  logic [CNT_W-1:0]         n_eff;
  logic [ADDR_W-1:0]        rd_idx;
  logic [ADDR_W-1:0]        raddr;
  logic                     mem_we;
  logic [MEM_W-1:0]         rdata;
  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] cur_y;
  logic signed [DATA_W-1:0] q_x;
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] prev_y;
  logic signed [DATA_W-1:0] hit_x;
  logic signed [DATA_W-1:0] hit_y;
  logic [DATA_W-1:0]        d_reg;
  logic [DATA_W-1:0]        t_reg;
  logic [DATA_W:0]          mag;
  logic                     neg;
  logic [DATA_W:0]          dy;
  logic [47:0]              pp_lo;
  logic [48:0]              pp_hi;
  logic [DIV_NUM_W-1:0]     num;
  logic                     hit;
  logic                     last;
  logic                     res_load;
  pli_out_t                 res_next;
  logic                     div_load;
  logic                     div_done;
  logic [DIV_Q_W-1:0]       quot;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign n_cfg = (int'(points_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(points_in_use);

  assign mem_we = start && !busy && (item.command == CMD_WRITE) &&
                  (int'(item.entry_index) < TABLE_DEPTH);

  assign cur_x = rdata[MEM_W-1:DATA_W];
  assign cur_y = rdata[DATA_W-1:0];
  assign hit   = (prev_x <= q_x) && (cur_x >= q_x);
  assign last  = (CNT_W'(rd_idx) == n_eff - CNT_W'(1));

  assign dy  = {prev_y[DATA_W-1], prev_y} - {hit_y[DATA_W-1], hit_y};
  assign num = DIV_NUM_W'(pp_lo) + (DIV_NUM_W'(pp_hi) << 16) +
               DIV_NUM_W'(d_reg >> 1);

  pli_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'(item.entry_index)),
    .wdata ({item.point_x, item.point_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  pli_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (div_load),
    .num  (num),
    .den  (d_reg),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    res_load   = 1'b0;
    res_next   = '{result_y: FALLBACK_Y, found: 1'b0};
    div_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start && item.command == CMD_QUERY) begin
          if (n_cfg < CNT_W'(2)) begin
            res_load = 1'b1;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        raddr = rd_idx + ADDR_W'(1);
        if (rd_idx != '0) begin
          if (hit) begin
            state_next = ST_PREP;
          end else if (last) begin
            res_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_PREP: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (d_reg == '0) begin
          res_load   = 1'b1;
          res_next   = '{result_y: hit_y, found: 1'b1};
          state_next = ST_IDLE;
        end else begin
          div_load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_load   = 1'b1;
          res_next   = '{result_y: neg ? hit_y - $signed(quot[DATA_W-1:0])
                                       : hit_y + $signed(quot[DATA_W-1:0]),
                         found: 1'b1};
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
      result_valid  <= 1'b0;
      rd_idx        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        points_in_use <= cfg_data;
      end
      result_valid <= res_load;
      if (state == ST_IDLE) begin
        rd_idx <= '0;
      end else if (state == ST_SCAN) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
    if (state == ST_IDLE) begin
      q_x   <= item.query_x;
      n_eff <= n_cfg;
    end
    if (state == ST_SCAN && !(rd_idx != '0 && hit)) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (state == ST_SCAN) begin
      hit_x <= cur_x;
      hit_y <= cur_y;
    end
    if (state == ST_PREP) begin
      d_reg <= hit_x - prev_x;
      t_reg <= hit_x - q_x;
      neg   <= dy[DATA_W];
      mag   <= dy[DATA_W] ? -dy : dy;
    end
    if (state == ST_MUL) begin
      pp_lo <= mag[15:0] * t_reg;
      pp_hi <= mag[DATA_W:16] * t_reg;
    end
  end

endmodule

// ===== rtl/pli_checker.sv =====
`include "assert_macros.svh"

module pli_checker import pli_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input pli_in_t  item,
  input logic     result_valid,
  input pli_out_t result
);

  // a breakpoint write is done at once
  `PLI_ASSERT_NEXT(a_write_quiet, start && !busy && item.command == CMD_WRITE, !busy && !result_valid, "write beat raised busy or gave a result")

  `PLI_ASSERT_SAME(a_result_idle, result_valid, !busy, "result shown while busy")

  `PLI_ASSERT_SAME(a_miss_value, result_valid && !result.found, result.result_y == FALLBACK_Y, "miss without fallback value")

  `PLI_ASSERT_SAME(a_busy_cause, $rose(busy), $past(start && item.command == CMD_QUERY), "busy without a query beat")

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);

// ===== test/tb_piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator;
  import pli_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int CALM_TAIL = 70;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS = 25;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;

  typedef enum logic {
    ROW_BEAT,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_W-1:0] cfg;
    pli_in_t          beat;
    bit               known;
    pli_out_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  pli_in_t item;
  logic result_valid;
  pli_out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH_DEF];
  logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH_DEF];
  logic [CFG_W-1:0] points_in_use;
  pli_out_t expected_results [$];
  pli_out_t oldest;
  int mismatches = 0;
  int beats_sent = 0;
  int cycles = 0;
  bit idle_on;
  stim_row_t dir_rows [DIR_ROWS];

  piecewise_linear_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH_DEF)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pli_in_t rand_beat();
    pli_in_t b;
    b.command = pli_cmd_t'($urandom_range(0, 1));
    b.entry_index = IDX_W'($urandom);
    b.point_x = $urandom;
    b.point_y = $urandom;
    b.query_x = $urandom;
    return b;
  endfunction

  function automatic stim_row_t row_write(input int idx, input logic signed [DATA_W-1:0] x,
                                          input logic signed [DATA_W-1:0] y);
    stim_row_t r;
    r.kind = ROW_BEAT;
    r.cfg = '0;
    r.beat = rand_beat();
    r.beat.command = CMD_WRITE;
    r.beat.entry_index = IDX_W'(idx);
    r.beat.point_x = x;
    r.beat.point_y = y;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t row_query(input logic signed [DATA_W-1:0] q, input bit known,
                                          input logic signed [DATA_W-1:0] y, input logic hit);
    stim_row_t r;
    r.kind = ROW_BEAT;
    r.cfg = '0;
    r.beat = rand_beat();
    r.beat.command = CMD_QUERY;
    r.beat.query_x = q;
    r.known = known;
    r.want.result_y = y;
    r.want.found = hit;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input int v);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.cfg = CFG_W'(v);
    r.beat = rand_beat();
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // scan segments in order, round half away from zero on the magnitude
  function automatic pli_out_t interpolate_at(input logic signed [DATA_W-1:0] qx);
    pli_out_t r;
    int n;
    longint q, xl, xr, yl, yr, dy, lin;
    longint unsigned t, d, mag, m;
    r.result_y = FALLBACK_Y;
    r.found = 1'b0;
    n = (points_in_use > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(points_in_use);
    q = qx;
    for (int i = 1; i < n && !r.found; i++) begin
      xl = bp_x[i-1];
      xr = bp_x[i];
      if (xl <= q && xr >= q) begin
        yl = bp_y[i-1];
        yr = bp_y[i];
        d = xr - xl;
        if (d == 0) begin
          lin = yr;
        end else begin
          t = xr - q;
          dy = yl - yr;
          mag = (dy < 0) ? -dy : dy;
          m = (mag * t + d / 2) / d;
          lin = (dy < 0) ? yr - longint'(m) : yr + longint'(m);
        end
        r.result_y = lin[DATA_W-1:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_query_x(input int n);
    longint lo, hi;
    int k;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (n < 2 || roll < 35) return $urandom;
    if (roll < 50) return bp_x[$urandom_range(0, n - 1)];
    k = $urandom_range(1, n - 1);
    lo = bp_x[k-1];
    hi = bp_x[k];
    if (hi < lo) return $urandom;
    lo = lo + $urandom_range(0, 32'(hi - lo));
    return lo[DATA_W-1:0];
  endfunction

  task automatic send_beat(input pli_in_t b, input bit known, input pli_out_t want);
    int gap;
    pli_out_t guess;
    start <= 1'b1;
    item <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (b.command == CMD_WRITE) begin
      bp_x[b.entry_index] = b.point_x;
      bp_y[b.entry_index] = b.point_y;
    end else begin
      guess = interpolate_at(b.query_x);
      expected_results.push_back(known ? want : guess);
    end
    @(negedge clk);
    gap = 0;
    if (idle_on && beats_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
    end
    if (gap > 0) begin
      start <= 1'b0;
      item <= rand_beat();
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_points_in_use(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    points_in_use = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ascending abscissas spread over the full range, some repeated
  task automatic load_sorted(input int n);
    longint span, x;
    pli_in_t b;
    span = 64'sd4294967296 / n;
    for (int k = 0; k < n; k++) begin
      x = -64'sd2147483648 + k * span + longint'($urandom_range(0, 32'(span - 1)));
      if (k > 0 && $urandom_range(0, 7) == 0) x = bp_x[k-1];
      b = rand_beat();
      b.command = CMD_WRITE;
      b.entry_index = IDX_W'(k);
      b.point_x = x[DATA_W-1:0];
      send_beat(b, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: result_y=%h found=%b",
                   result.result_y, result.found);
        end
      end else begin
        oldest = expected_results.pop_front();
        if (result.result_y !== oldest.result_y || result.found !== oldest.found) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected result_y=%h found=%b, got result_y=%h found=%b",
                     oldest.result_y, oldest.found, result.result_y, result.found);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int n_eff;
    int burst;
    logic [CFG_W-1:0] setting;
    pli_in_t b;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    points_in_use = '0;
    idle_on = 1'b1;
    dir_rows = '{
      row_query('0, 1'b1, FALLBACK_Y, 1'b0),
      row_cfg(1),
      row_query(Q_MAX, 1'b1, FALLBACK_Y, 1'b0),
      row_write(0, Q_MIN, Q_MAX),
      row_write(1, Q_MIN, 32'sh1234_0000),
      row_write(2, '0, Q_MIN),
      row_write(3, Q_MAX, Q_MAX),
      row_cfg(4),
      row_query(Q_MIN, 1'b1, 32'sh1234_0000, 1'b1),
      row_query('0, 1'b1, Q_MIN, 1'b1),
      row_query(Q_MAX, 1'b1, Q_MAX, 1'b1),
      row_query(-32'sd1, 1'b0, '0, 1'b0),
      row_query(32'sd1, 1'b0, '0, 1'b0),
      row_query(32'sh4000_0000, 1'b0, '0, 1'b0),
      row_cfg(3),
      row_query(Q_MAX, 1'b1, FALLBACK_Y, 1'b0),
      row_query(32'sd1, 1'b1, FALLBACK_Y, 1'b0),
      row_cfg(2),
      row_query(Q_MIN, 1'b1, 32'sh1234_0000, 1'b1),
      row_query('0, 1'b1, FALLBACK_Y, 1'b0),
      // half-way rounding on a two-unit segment, both slopes
      row_write(0, '0, '0),
      row_write(1, 32'sd2, 32'sd1),
      row_query(32'sd1, 1'b0, '0, 1'b0),
      row_write(1, 32'sd2, -32'sd1),
      row_query(32'sd1, 1'b0, '0, 1'b0)
    };
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain_and_settle();
        write_points_in_use(dir_rows[r].cfg);
      end else begin
        send_beat(dir_rows[r].beat, dir_rows[r].known, dir_rows[r].want);
      end
    end

    // every entry written before any wider table is scanned
    load_sorted(TABLE_DEPTH_DEF);

    while (beats_sent < ITEM_TARGET) begin
      drain_and_settle();
      case ($urandom_range(0, 9))
        0: setting = CFG_W'(0);
        1: setting = CFG_W'(1);
        2: setting = CFG_W'(2);
        3: setting = CFG_W'(TABLE_DEPTH_DEF);
        4: setting = {CFG_W{1'b1}};
        5: setting = CFG_W'($urandom_range(TABLE_DEPTH_DEF + 1, 62));
        default: setting = CFG_W'($urandom_range(3, TABLE_DEPTH_DEF - 1));
      endcase
      write_points_in_use(setting);
      n_eff = (setting > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(setting);
      idle_on = ($urandom_range(0, 3) != 0);
      if (n_eff >= 2) begin
        case ($urandom_range(0, 5))
          0: begin
            for (int k = 0; k < n_eff; k++) begin
              b = rand_beat();
              b.command = CMD_WRITE;
              b.entry_index = IDX_W'(k);
              send_beat(b, 1'b0, '0);
            end
          end
          1: ;
          default: load_sorted(n_eff);
        endcase
      end
      burst = $urandom_range(20, 40);
      repeat (burst) begin
        b = rand_beat();
        if ($urandom_range(0, 6) == 0) begin
          b.command = CMD_WRITE;
        end else begin
          b.command = CMD_QUERY;
          b.query_x = pick_query_x(n_eff);
        end
        send_beat(b, 1'b0, '0);
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
